FILE: src/cht_pkg.sv
// Shared types, constants and helpers for the cubic trajectory follower.
package cht_pkg;

   localparam int AXES          = 3;
   localparam int VALUE_WIDTH   = 32;
   localparam int PERIOD_WIDTH  = 17;
   localparam int TIME_WIDTH    = 32;
   localparam int WIDE          = 64;
   localparam int QS            = 24;
   localparam int QT            = 16;
   localparam int MUL_DIGIT     = 16;
   localparam int MUL_STEPS     = WIDE / MUL_DIGIT;
   localparam int MUL_STEP_BITS = $clog2(MUL_STEPS);
   localparam int DIV_STEPS     = WIDE / 2;
   localparam int DIV_STEP_BITS = $clog2(DIV_STEPS);

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(66);

   typedef logic signed [WIDE-1:0]        wide_type;
   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [TIME_WIDTH-1:0]         time_type;

   localparam wide_type ONE_S = wide_type'(1) <<< QS;
   localparam wide_type VMAX  = (wide_type'(1) <<< (VALUE_WIDTH - 1)) - wide_type'(1);
   localparam wide_type VMIN  = -VMAX - wide_type'(1);

   typedef enum logic {SHIFT_Q24, SHIFT_Q16} shift_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LAUNCH, ST_COEF, ST_LANES, ST_DONE
   } ctl_state_type;

   typedef enum logic [1:0] {CF_IDLE, CF_DIV, CF_SQ, CF_CUBE} coef_state_type;

   typedef enum logic [3:0] {
      LN_IDLE, LN_DPHP, LN_V0T, LN_V0H, LN_V1T, LN_V1H, LN_DPG, LN_DIV, LN_V0C, LN_V1C
   } lane_state_type;

   typedef struct packed {
      wide_type hp;
      wide_type hv0;
      wide_type hv1;
      wide_type g;
      wide_type c0;
      wide_type c1;
   } coef_type;

   typedef struct packed {
      logic start;
      logic load;
   } lane_ctrl_type;

   function automatic value_type clamp_value(input wide_type x);
      value_type r;
      if (x > VMAX) begin
         r = VMAX[VALUE_WIDTH-1:0];
      end else if (x < VMIN) begin
         r = VMIN[VALUE_WIDTH-1:0];
      end else begin
         r = x[VALUE_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/cubic_trajectory_follower.sv
// Cubic Hermite trajectory follower: per-axis lanes, shared weight unit, result register.
// An interpolation step runs the weight unit's divider and then its two multiplies, then each
// lane's eight multiplies and its divider; a snap or preset loads the targets straight into the lanes.
// A new transaction is accepted only after the last one has moved to the output register; a result
// waiting in the output register does not block acceptance. Synchronous reset returns to idle,
// clears the lanes' position and velocity and sets the period to its reset value.
module cubic_trajectory_follower import cht_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  value_type               req_target_pos_x,
   input  value_type               req_target_pos_y,
   input  value_type               req_target_pos_z,
   input  value_type               req_target_vel_x,
   input  value_type               req_target_vel_y,
   input  value_type               req_target_vel_z,
   input  time_type                req_now_time,
   input  time_type                req_arrival_time,
   input  logic                    req_mode,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output value_type               rsp_pos_x,
   output value_type               rsp_pos_y,
   output value_type               rsp_pos_z,
   output value_type               rsp_vel_x,
   output value_type               rsp_vel_y,
   output value_type               rsp_vel_z,
   output logic                    rsp_snapped,
   input  logic                    csr_write_en,
   input  logic [PERIOD_WIDTH-1:0] csr_write_data
);

   ctl_state_type             state_ff, state_in;
   logic [PERIOD_WIDTH-1:0]   period_ff;
   value_type                 tpos_ff [AXES];
   value_type                 tvel_ff [AXES];
   value_type                 in_pos [AXES];
   value_type                 in_vel [AXES];
   value_type                 lane_pos [AXES];
   value_type                 lane_vel [AXES];
   value_type                 out_pos_ff [AXES];
   value_type                 out_vel_ff [AXES];
   time_type                  t_ff;
   logic                      snap_ff, out_snap_ff, rsp_valid_ff, rsp_valid_in;
   logic [AXES-1:0]           lane_done, seen_ff, seen_in;
   logic                      accept, coef_start, coef_done, out_load, snap_now;
   logic signed [TIME_WIDTH:0]   t_signed;
   logic signed [TIME_WIDTH+4:0] ten_t;
   lane_ctrl_type             lane_ctrl;
   coef_type                  coef;

   assign in_pos[0] = req_target_pos_x;
   assign in_pos[1] = req_target_pos_y;
   assign in_pos[2] = req_target_pos_z;
   assign in_vel[0] = req_target_vel_x;
   assign in_vel[1] = req_target_vel_y;
   assign in_vel[2] = req_target_vel_z;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Snap on a preset, or when ten times the remaining time does not exceed the period.
   assign t_signed = $signed({1'b0, req_arrival_time}) - $signed({1'b0, req_now_time});
   assign ten_t    = (($bits(ten_t))'(t_signed) <<< 3) + (($bits(ten_t))'(t_signed) <<< 1);
   assign snap_now = req_mode || (ten_t <= $signed({1'b0, ($bits(ten_t) - 1)'(period_ff)}));

   cht_coef u_coef (
      .clock(clock), .reset(reset), .start(coef_start), .period(period_ff), .t(t_ff),
      .done(coef_done), .coef(coef)
   );

   for (genvar i = 0; i < AXES; i++) begin : g_lane
      cht_lane u_lane (
         .clock(clock), .reset(reset), .ctrl(lane_ctrl), .p1(tpos_ff[i]), .v1(tvel_ff[i]),
         .t(t_ff), .coef(coef), .done(lane_done[i]), .pos(lane_pos[i]), .vel(lane_vel[i])
      );
   end

   always_comb begin
      state_in        = state_ff;
      coef_start      = 1'b0;
      lane_ctrl.start = 1'b0;
      lane_ctrl.load  = 1'b0;
      out_load        = 1'b0;
      seen_in         = seen_ff | lane_done;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            if (snap_ff) begin
               lane_ctrl.load = 1'b1;
               state_in       = ST_DONE;
            end else begin
               coef_start = 1'b1;
               state_in   = ST_COEF;
            end
         end
         ST_COEF: begin
            if (coef_done) begin
               lane_ctrl.start = 1'b1;
               seen_in         = '0;
               state_in        = ST_LANES;
            end
         end
         ST_LANES: begin
            if (&seen_in) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         if (csr_write_en) begin
            period_ff <= csr_write_data;
         end
      end
      if (accept) begin
         t_ff    <= t_signed[TIME_WIDTH-1:0];
         snap_ff <= snap_now;
         for (int i = 0; i < AXES; i++) begin
            tpos_ff[i] <= in_pos[i];
            tvel_ff[i] <= in_vel[i];
         end
      end
      if (out_load) begin
         out_snap_ff <= snap_ff;
         for (int i = 0; i < AXES; i++) begin
            out_pos_ff[i] <= lane_pos[i];
            out_vel_ff[i] <= lane_vel[i];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = out_pos_ff[0];
   assign rsp_pos_y   = out_pos_ff[1];
   assign rsp_pos_z   = out_pos_ff[2];
   assign rsp_vel_x   = out_vel_ff[0];
   assign rsp_vel_y   = out_vel_ff[1];
   assign rsp_vel_z   = out_vel_ff[2];
   assign rsp_snapped = out_snap_ff;

endmodule

FILE: src/cht_mul.sv
// Sequential signed multiplier, 16-bit digit per cycle, product shifted back toward zero.
module cht_mul import cht_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  wide_type  a,
   input  wide_type  b,
   input  shift_type shift,
   output logic      done,
   output wide_type  result
);

   logic [WIDE-1:0]          amag_ff, amag_in, bmag_ff, bmag_in, lo_ff, lo_in;
   logic [WIDE:0]            hi_ff, hi_in;
   logic                     neg_ff, neg_in, run_ff, run_in, fin_ff, fin_in, done_ff, done_in;
   logic [MUL_STEP_BITS-1:0] step_ff, step_in;
   shift_type                shift_ff, shift_in;
   wide_type                 result_ff, result_in;
   logic [WIDE+MUL_DIGIT-1:0] partial;
   logic [WIDE+MUL_DIGIT:0]   sum;
   logic [2*WIDE-1:0]         prod, mag;

   always_comb begin
      partial = {{MUL_DIGIT{1'b0}}, amag_ff} * {{WIDE{1'b0}}, bmag_ff[MUL_DIGIT-1:0]};
      sum     = {{MUL_DIGIT{1'b0}}, hi_ff} + {1'b0, partial};
      prod    = {hi_ff[WIDE-1:0], lo_ff};
      if (shift_ff == SHIFT_Q24) begin
         mag = prod >> QS;
      end else begin
         mag = prod >> QT;
      end

      amag_in   = amag_ff;
      bmag_in   = bmag_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      neg_in    = neg_ff;
      run_in    = run_ff;
      fin_in    = 1'b0;
      done_in   = 1'b0;
      step_in   = step_ff;
      shift_in  = shift_ff;
      result_in = result_ff;

      if (start) begin
         amag_in  = a[WIDE-1] ? (~a + 1'b1) : a;
         bmag_in  = b[WIDE-1] ? (~b + 1'b1) : b;
         neg_in   = a[WIDE-1] ^ b[WIDE-1];
         hi_in    = '0;
         lo_in    = '0;
         step_in  = '0;
         shift_in = shift;
         run_in   = 1'b1;
      end else if (run_ff) begin
         // Low digit of each partial sum retires into the low half of the product.
         hi_in   = sum[WIDE+MUL_DIGIT:MUL_DIGIT];
         lo_in   = {sum[MUL_DIGIT-1:0], lo_ff[WIDE-1:MUL_DIGIT]};
         bmag_in = bmag_ff >> MUL_DIGIT;
         step_in = step_ff + 1'b1;
         if (step_ff == MUL_STEP_BITS'(MUL_STEPS - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         result_in = neg_ff ? -wide_type'(mag[WIDE-1:0]) : wide_type'(mag[WIDE-1:0]);
         done_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      amag_ff   <= amag_in;
      bmag_ff   <= bmag_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      neg_ff    <= neg_in;
      step_ff   <= step_in;
      shift_ff  <= shift_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

FILE: src/cht_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
module cht_div import cht_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [WIDE-1:0] num,
   input  time_type        den,
   output logic            done,
   output logic [WIDE-1:0] quot
);

   logic [WIDE-1:0]          num_ff, num_in, quot_ff, quot_in;
   time_type                 rem_ff, rem_in, den_ff, den_in;
   logic [DIV_STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                     run_ff, run_in, done_ff, done_in;
   logic [TIME_WIDTH:0]      st1, st2;

   function automatic logic [TIME_WIDTH:0] div_step(input time_type rem, input logic nbit,
                                                    input time_type d);
      logic [TIME_WIDTH:0] trial;
      logic [TIME_WIDTH:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         return {1'b1, diff[TIME_WIDTH-1:0]};
      end
      return {1'b0, trial[TIME_WIDTH-1:0]};
   endfunction

   always_comb begin
      st1 = div_step(rem_ff, num_ff[WIDE-1], den_ff);
      st2 = div_step(st1[TIME_WIDTH-1:0], num_ff[WIDE-2], den_ff);

      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = DIV_STEP_BITS'(DIV_STEPS - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         num_in  = num_ff << 2;
         quot_in = {quot_ff[WIDE-3:0], st1[TIME_WIDTH], st2[TIME_WIDTH]};
         rem_in  = st2[TIME_WIDTH-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: src/cht_coef.sv
// Computes the step fraction s = h / T and the Hermite weights shared by all axes.
module cht_coef import cht_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [PERIOD_WIDTH-1:0] period,
   input  time_type                t,
   output logic                    done,
   output coef_type                coef
);

   coef_state_type  state_ff, state_in;
   wide_type        s_ff, s_in, s2_ff, s2_in, s3_ff, s3_in;
   logic            done_ff, done_in;
   logic            div_start, div_done, mul_start, mul_done;
   logic [WIDE-1:0] div_num, div_quot;
   wide_type        mul_a, mul_b, mul_res;

   assign div_num = WIDE'(period) << QS;

   cht_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(t),
      .done(div_done), .quot(div_quot)
   );

   cht_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .shift(SHIFT_Q24), .done(mul_done), .result(mul_res)
   );

   always_comb begin
      state_in  = state_ff;
      s_in      = s_ff;
      s2_in     = s2_ff;
      s3_in     = s3_ff;
      done_in   = 1'b0;
      div_start = 1'b0;
      mul_start = 1'b0;
      mul_a     = wide_type'(div_quot);
      mul_b     = wide_type'(div_quot);
      unique case (state_ff)
         CF_IDLE: begin
            if (start) begin
               div_start = 1'b1;
               state_in  = CF_DIV;
            end
         end
         CF_DIV: begin
            if (div_done) begin
               s_in      = wide_type'(div_quot);
               mul_start = 1'b1;
               state_in  = CF_SQ;
            end
         end
         CF_SQ: begin
            mul_a = mul_res;
            mul_b = s_ff;
            if (mul_done) begin
               s2_in     = mul_res;
               mul_start = 1'b1;
               state_in  = CF_CUBE;
            end
         end
         CF_CUBE: begin
            if (mul_done) begin
               s3_in    = mul_res;
               done_in  = 1'b1;
               state_in = CF_IDLE;
            end
         end
         default: state_in = CF_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CF_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      s_ff  <= s_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   always_comb begin
      coef.hp  = (s2_ff <<< 1) + s2_ff - (s3_ff <<< 1);
      coef.hv0 = s_ff - (s2_ff <<< 1) + s3_ff;
      coef.hv1 = s3_ff - s2_ff;
      coef.g   = (s_ff <<< 2) + (s_ff <<< 1) - (s2_ff <<< 2) - (s2_ff <<< 1);
      coef.c0  = ONE_S - (s_ff <<< 2) + (s2_ff <<< 1) + s2_ff;
      coef.c1  = (s2_ff <<< 1) + s2_ff - (s_ff <<< 1);
   end

   assign done = done_ff;

endmodule

FILE: src/cht_lane.sv
// One axis: holds its position and velocity and steps them along the Hermite curve.
module cht_lane import cht_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  value_type     p1,
   input  value_type     v1,
   input  time_type      t,
   input  coef_type      coef,
   output logic          done,
   output value_type     pos,
   output value_type     vel
);

   lane_state_type  state_ff, state_in;
   logic            launch_ff, launch_in, done_ff, done_in;
   value_type       p_ff, p_in, v_ff, v_in;
   wide_type        accp_ff, accp_in, accv_ff, accv_in, tmp_ff, tmp_in;
   wide_type        dp, v0w, v1w, tw, mul_a, mul_b, mul_res, vdiv;
   shift_type       mul_shift;
   logic            mul_start, mul_done, div_start, div_done;
   logic [WIDE-1:0] tmag, div_num, div_quot;

   assign dp   = wide_type'(p1) - wide_type'(p_ff);
   assign v0w  = wide_type'(v_ff);
   assign v1w  = wide_type'(v1);
   assign tw   = wide_type'(t);
   assign tmag = tmp_ff[WIDE-1] ? (~tmp_ff + 1'b1) : tmp_ff;
   // Scaling by 2^16 before the divide keeps the quotient in Q16.16.
   assign div_num = tmag << QT;
   assign vdiv    = tmp_ff[WIDE-1] ? -wide_type'(div_quot) : wide_type'(div_quot);

   assign mul_start = launch_ff && (state_ff != LN_DIV);
   assign div_start = launch_ff && (state_ff == LN_DIV);

   cht_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .shift(mul_shift), .done(mul_done), .result(mul_res)
   );

   cht_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(t),
      .done(div_done), .quot(div_quot)
   );

   always_comb begin
      mul_a     = dp;
      mul_b     = coef.hp;
      mul_shift = SHIFT_Q24;
      unique case (state_ff)
         LN_V0T: begin
            mul_a     = v0w;
            mul_b     = tw;
            mul_shift = SHIFT_Q16;
         end
         LN_V0H: begin
            mul_a = tmp_ff;
            mul_b = coef.hv0;
         end
         LN_V1T: begin
            mul_a     = v1w;
            mul_b     = tw;
            mul_shift = SHIFT_Q16;
         end
         LN_V1H: begin
            mul_a = tmp_ff;
            mul_b = coef.hv1;
         end
         LN_DPG: mul_b = coef.g;
         LN_V0C: begin
            mul_a = v0w;
            mul_b = coef.c0;
         end
         LN_V1C: begin
            mul_a = v1w;
            mul_b = coef.c1;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      launch_in = 1'b0;
      done_in   = 1'b0;
      p_in      = p_ff;
      v_in      = v_ff;
      accp_in   = accp_ff;
      accv_in   = accv_ff;
      tmp_in    = tmp_ff;
      unique case (state_ff)
         LN_IDLE: begin
            if (ctrl.load) begin
               p_in = p1;
               v_in = v1;
            end else if (ctrl.start) begin
               accp_in   = wide_type'(p_ff);
               state_in  = LN_DPHP;
               launch_in = 1'b1;
            end
         end
         LN_DPHP: begin
            if (mul_done) begin
               accp_in   = accp_ff + mul_res;
               state_in  = LN_V0T;
               launch_in = 1'b1;
            end
         end
         LN_V0T: begin
            if (mul_done) begin
               tmp_in    = mul_res;
               state_in  = LN_V0H;
               launch_in = 1'b1;
            end
         end
         LN_V0H: begin
            if (mul_done) begin
               accp_in   = accp_ff + mul_res;
               state_in  = LN_V1T;
               launch_in = 1'b1;
            end
         end
         LN_V1T: begin
            if (mul_done) begin
               tmp_in    = mul_res;
               state_in  = LN_V1H;
               launch_in = 1'b1;
            end
         end
         LN_V1H: begin
            if (mul_done) begin
               accp_in   = accp_ff + mul_res;
               state_in  = LN_DPG;
               launch_in = 1'b1;
            end
         end
         LN_DPG: begin
            if (mul_done) begin
               tmp_in    = mul_res;
               state_in  = LN_DIV;
               launch_in = 1'b1;
            end
         end
         LN_DIV: begin
            if (div_done) begin
               accv_in   = vdiv;
               state_in  = LN_V0C;
               launch_in = 1'b1;
            end
         end
         LN_V0C: begin
            if (mul_done) begin
               accv_in   = accv_ff + mul_res;
               state_in  = LN_V1C;
               launch_in = 1'b1;
            end
         end
         LN_V1C: begin
            if (mul_done) begin
               p_in     = clamp_value(accp_ff);
               v_in     = clamp_value(accv_ff + mul_res);
               done_in  = 1'b1;
               state_in = LN_IDLE;
            end
         end
         default: state_in = LN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= LN_IDLE;
         launch_ff <= 1'b0;
         done_ff   <= 1'b0;
         p_ff      <= '0;
         v_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         done_ff   <= done_in;
         p_ff      <= p_in;
         v_ff      <= v_in;
      end
      accp_ff <= accp_in;
      accv_ff <= accv_in;
      tmp_ff  <= tmp_in;
   end

   assign done = done_ff;
   assign pos  = p_ff;
   assign vel  = v_ff;

endmodule

FILE: src/cht_checker.sv
// Port-level checks for the trajectory follower, bound to the top level.
module cht_checker import cht_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input value_type rsp_pos_x,
   input value_type rsp_vel_x,
   input logic      rsp_snapped
);

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pos_x) && $stable(rsp_vel_x)
                                  && $stable(rsp_snapped))
      else $error("stalled result changed");

   // One transaction is worked on at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while one is in flight");

   // No result can be produced in the cycle right after an acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early after acceptance");

endmodule

bind cubic_trajectory_follower cht_checker u_cht_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_pos_x(rsp_pos_x),
   .rsp_vel_x(rsp_vel_x), .rsp_snapped(rsp_snapped)
);

FILE: bench/tb_cubic_trajectory_follower.sv
// Self-checking testbench for the cubic trajectory follower with a Q16.16 Hermite predictor.
module tb_cubic_trajectory_follower;
   import cht_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_STEP   = 1'b0;
   localparam logic MODE_PRESET = 1'b1;
   localparam int   STALL_LIMIT = 20000;

   typedef struct {
      value_type tpos[AXES];
      value_type tvel[AXES];
      time_type  now_t;
      time_type  arr_t;
      logic      mode;
   } tick_type;

   typedef struct {
      value_type pos[AXES];
      value_type vel[AXES];
      logic      snapped;
   } setpoint_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   value_type req_tp[AXES];
   value_type req_tv[AXES];
   time_type req_now_time = '0, req_arrival_time = '0;
   logic req_mode = 1'b0;
   logic rsp_valid, rsp_ready = 1'b0;
   value_type rsp_p[AXES];
   value_type rsp_v[AXES];
   logic rsp_snapped;
   logic csr_write_en = 1'b0;
   logic [PERIOD_WIDTH-1:0] csr_write_data = '0;

   tick_type pending_ticks[$];
   setpoint_type expected_setpoints[$];
   int send_idle_pct = 0, recv_stall_pct = 0;
   int failures = 0, quiet_cycles = 0;

   // Predictor state.
   logic [PERIOD_WIDTH-1:0] period_model;
   logic signed [63:0] pos_model[AXES];
   logic signed [63:0] vel_model[AXES];

   initial begin
      for (int i = 0; i < AXES; i++) begin
         req_tp[i] = '0;
         req_tv[i] = '0;
      end
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cubic_trajectory_follower dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_target_pos_x(req_tp[0]), .req_target_pos_y(req_tp[1]),
      .req_target_pos_z(req_tp[2]),
      .req_target_vel_x(req_tv[0]), .req_target_vel_y(req_tv[1]),
      .req_target_vel_z(req_tv[2]),
      .req_now_time(req_now_time), .req_arrival_time(req_arrival_time),
      .req_mode(req_mode),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pos_x(rsp_p[0]), .rsp_pos_y(rsp_p[1]), .rsp_pos_z(rsp_p[2]),
      .rsp_vel_x(rsp_v[0]), .rsp_vel_y(rsp_v[1]), .rsp_vel_z(rsp_v[2]),
      .rsp_snapped(rsp_snapped),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
   endfunction

   // Exact product shifted toward zero, saturated to 64 bits.
   function automatic logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                         logic signed [63:0] b, int k);
      logic neg;
      logic [63:0] x, y;
      logic [127:0] m;
      neg = (a < 0) != (b < 0);
      x = a < 0 ? -a : a;
      y = b < 0 ? -b : b;
      m = (128'(x) * 128'(y)) >> k;
      if (m[127:63] != 0) begin
         if (neg && m == 128'h8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
         return neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
   endfunction

   function automatic logic signed [63:0] divide_by_time(logic signed [63:0] x,
                                                         logic signed [63:0] t);
      logic signed [63:0] q, r;
      q = x / t;
      r = x % t;
      if (q > (64'sd1 <<< 46)) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (q < -(64'sd1 <<< 46)) return 64'sh8000_0000_0000_0000;
      return q * 65536 + (r * 65536) / t;
   endfunction

   function automatic setpoint_type advance_follower(tick_type tk);
      setpoint_type sp;
      logic signed [63:0] t, h, s, s2, s3, hp, hv0, hv1, g, c0, c1, dp, pn, vn;
      logic snap;
      h = 64'(period_model);
      t = 64'(tk.arr_t) - 64'(tk.now_t);
      snap = (tk.mode == MODE_PRESET) || (10 * t <= h);
      if (snap) begin
         for (int i = 0; i < AXES; i++) begin
            pos_model[i] = tk.tpos[i];
            vel_model[i] = tk.tvel[i];
         end
      end else begin
         s = $signed((64'(period_model) << QS) / $unsigned(t));
         s2 = $signed(($unsigned(s) * $unsigned(s)) >> QS);
         s3 = $signed(($unsigned(s2) * $unsigned(s)) >> QS);
         hp = 3 * s2 - 2 * s3;
         hv0 = s - 2 * s2 + s3;
         hv1 = s3 - s2;
         g = 6 * s - 6 * s2;
         c0 = ONE_S - 4 * s + 3 * s2;
         c1 = 3 * s2 - 2 * s;
         for (int i = 0; i < AXES; i++) begin
            dp = 64'(tk.tpos[i]) - pos_model[i];
            pn = pos_model[i];
            pn = sat_add(pn, scaled_product(dp, hp, QS));
            pn = sat_add(pn, scaled_product(scaled_product(vel_model[i], t, QT), hv0, QS));
            pn = sat_add(pn, scaled_product(scaled_product(64'(tk.tvel[i]), t, QT), hv1, QS));
            vn = divide_by_time(scaled_product(dp, g, QS), t);
            vn = sat_add(vn, scaled_product(vel_model[i], c0, QS));
            vn = sat_add(vn, scaled_product(64'(tk.tvel[i]), c1, QS));
            pos_model[i] = 64'(clamp_value(pn));
            vel_model[i] = 64'(clamp_value(vn));
         end
      end
      for (int i = 0; i < AXES; i++) begin
         sp.pos[i] = pos_model[i][VALUE_WIDTH-1:0];
         sp.vel[i] = vel_model[i][VALUE_WIDTH-1:0];
      end
      sp.snapped = snap;
      return sp;
   endfunction

   // Driver: present the next pending tick, holding it until the transaction.
   // An accepted tick has already left the queue, so the next one is at its front.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_setpoints.push_back(advance_follower(pending_ticks.pop_front()));
         end
         if ((!req_valid || req_ready) && pending_ticks.size() > 0
             && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            for (int i = 0; i < AXES; i++) begin
               req_tp[i] <= pending_ticks[0].tpos[i];
               req_tv[i] <= pending_ticks[0].tvel[i];
            end
            req_now_time <= pending_ticks[0].now_t;
            req_arrival_time <= pending_ticks[0].arr_t;
            req_mode <= pending_ticks[0].mode;
         end else if (req_valid && req_ready) begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor and scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_setpoints.size() == 0) begin
               $display("%0t: unexpected setpoint pos_x=%h", $realtime, rsp_p[0]);
               failures++;
            end else begin
               setpoint_type e;
               e = expected_setpoints.pop_front();
               for (int i = 0; i < AXES; i++) begin
                  if (rsp_p[i] !== e.pos[i]) begin
                     $display("%0t: pos[%0d] expected %h actual %h", $realtime, i,
                              e.pos[i], rsp_p[i]);
                     failures++;
                  end
                  if (rsp_v[i] !== e.vel[i]) begin
                     $display("%0t: vel[%0d] expected %h actual %h", $realtime, i,
                              e.vel[i], rsp_v[i]);
                     failures++;
                  end
               end
               if (rsp_snapped !== e.snapped) begin
                  $display("%0t: snapped expected %b actual %b", $realtime, e.snapped,
                           rsp_snapped);
                  failures++;
               end
            end
         end
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic value_type random_value();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return value_type'($urandom);
         default: return value_type'($signed($urandom_range(20 << 16)) - (10 << 16));
      endcase
   endfunction

   function automatic tick_type make_tick(value_type p, value_type v, time_type n,
                                          time_type a, logic m);
      tick_type tk;
      for (int i = 0; i < AXES; i++) begin
         tk.tpos[i] = p + value_type'(i * 4099);
         tk.tvel[i] = v - value_type'(i * 257);
      end
      tk.now_t = n;
      tk.arr_t = a;
      tk.mode = m;
      return tk;
   endfunction

   function automatic tick_type random_tick();
      tick_type tk;
      int unsigned span;
      for (int i = 0; i < AXES; i++) begin
         tk.tpos[i] = random_value();
         tk.tvel[i] = random_value();
      end
      tk.now_t = $urandom;
      case ($urandom_range(9))
         0: span = 0;
         1: span = $urandom;
         2: span = $urandom_range(period_model / 10 + 1);
         default: span = $urandom_range(32'(period_model) * 40 + 2);
      endcase
      tk.arr_t = tk.now_t + span;
      if ($urandom_range(15) == 0) tk.arr_t = $urandom;
      tk.mode = ($urandom_range(19) == 0) ? MODE_PRESET : MODE_STEP;
      return tk;
   endfunction

   task automatic drain_and_set_period(logic [PERIOD_WIDTH-1:0] p);
      while (pending_ticks.size() > 0 || req_valid || expected_setpoints.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= p;
      @(posedge clock);
      csr_write_en <= 1'b0;
      period_model = p;
   endtask

   initial begin
      logic [PERIOD_WIDTH-1:0] periods[6] = '{17'd1, 17'd66, 17'd65536, 17'h1FFFF,
                                              17'd0, 17'd6554};
      int idles[4] = '{0, 77, 0, 31};
      int stalls[4] = '{0, 0, 77, 31};
      period_model = PERIOD_RESET;
      for (int i = 0; i < AXES; i++) begin
         pos_model[i] = 0;
         vel_model[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // Directed: extremes, preset, snapping, zero and long remaining time, reset period.
      pending_ticks.push_back(make_tick(32'sh0001_0000, 32'sh0, 0, 32'h0010_0000, MODE_STEP));
      pending_ticks.push_back(make_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 5, 5, MODE_STEP));
      pending_ticks.push_back(make_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 100, 90, MODE_STEP));
      pending_ticks.push_back(make_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 32'hFFFF_FFFF,
                                        MODE_STEP));
      pending_ticks.push_back(make_tick(32'sh8000_0000, 32'sh8000_0000, 0, 660, MODE_STEP));
      pending_ticks.push_back(make_tick(32'sh0, 32'sh0, 0, 6, MODE_STEP));
      pending_ticks.push_back(make_tick(32'sh0, 32'sh0, 0, 7, MODE_STEP));
      pending_ticks.push_back(make_tick(32'sh1234_5678, -32'sh0002_0000, 0, 32'hFFFF_FFFF,
                                        MODE_PRESET));
      pending_ticks.push_back(make_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 0,
                                        MODE_STEP));
      pending_ticks.push_back(make_tick(-32'sh0005_0000, 32'sh0003_0000, 1000, 1067,
                                        MODE_STEP));
      for (int i = 0; i < 4; i++)
         pending_ticks.push_back(make_tick(32'sh0040_0000, 32'sh0, i * 66, 400, MODE_STEP));
      for (int ph = 0; ph < 6; ph++) begin
         drain_and_set_period(periods[ph]);
         send_idle_pct = idles[ph % 4];
         recv_stall_pct = stalls[ph % 4];
         // A preset keeps phases from starting at the previous phase's saturated state.
         for (int n = 0; n < 232; n++) begin
            if (n % 40 == 0) pending_ticks.push_back(make_tick(random_value(),
               random_value(), 0, 0, MODE_PRESET));
            else pending_ticks.push_back(random_tick());
         end
      end
      while (pending_ticks.size() > 0 || req_valid || expected_setpoints.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0 && expected_setpoints.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
